// ----- rtl/tac_pkg.sv -----
// Shared types, constants and the resistance table of the thermistor converter.
`timescale 1ns / 1ps
package tac_pkg;

	localparam int TABLE_ENTRIES = 25;
	localparam int STD_POINTS    = 25;
	localparam int SEG_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int CODE_W = 12;
	localparam int RES_W  = 21;          // table entries and divisor
	localparam int PROD_W = 29;          // 100000 * code
	localparam int QUO_W  = 32;          // dividend / quotient shift register
	localparam int FRAC_W = 11;          // interpolation offset, 0..1280
	localparam int TEMP_W = 16;

	localparam int DIV1_ITERS = PROD_W;
	localparam int DIV2_ITERS = FRAC_W;
	localparam int CNT_W      = $clog2(DIV1_ITERS + 1);

	localparam logic [CODE_W-1:0] FULL_SCALE  = 12'hFFF;
	localparam logic [PROD_W-1:0] DIVIDER_R10 = 29'd100000;
	localparam logic [FRAC_W-1:0] STEP_SCALED = 11'd1280;
	localparam logic [TEMP_W-1:0] STEP_TEMP   = 16'd1280;
	localparam logic [TEMP_W-1:0] COLD_TEMP   = 16'(-20 * 256);
	localparam logic [TEMP_W-1:0] HOT_TEMP    = 16'((-20 + 5 * (TABLE_ENTRIES - 1)) * 256);

	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_COLD   = 2'd1;
	localparam logic [1:0] ST_HOT    = 2'd2;

	localparam logic [RES_W-1:0] RES_TAB [STD_POINTS] = '{
		21'd1146600, 21'd845100, 21'd629270, 21'd470770, 21'd355630, 21'd271190,
		21'd208600, 21'd162040, 21'd126830, 21'd100000, 21'd79420, 21'd63270,
		21'd50740, 21'd41030, 21'd33360, 21'd27240, 21'd22370, 21'd18460,
		21'd15300, 21'd12750, 21'd10680, 21'd8993, 21'd7607, 21'd6452, 21'd5494
	};

	// Points beyond the standard set read as zero.
	function automatic logic [RES_W-1:0] res_tab(input logic [SEG_W-1:0] idx);
		logic [4:0] i5;
		i5 = 5'(idx);
		if (32'(idx) < STD_POINTS)
			res_tab = RES_TAB[i5];
		else
			res_tab = '0;
	endfunction

	typedef struct packed {
		logic load_code;
		logic mul_load;
		logic div_step;
		logic check;
		logic seg_clr;
		logic seg_inc;
		logic prep;
		logic out_load;
	} tac_cmd_t;

	typedef struct packed {
		logic cold;
		logic hot;
		logic hit;
		logic seg_last;
	} tac_stat_t;

endpackage

// ----- rtl/tac_datapath.sv -----
// Datapath: multiplier, shared restoring divider, table search and result registers.
`timescale 1ns / 1ps
module tac_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tac_pkg::tac_cmd_t            cmd,
	output tac_pkg::tac_stat_t           stat,
	input  logic [tac_pkg::CODE_W-1:0]   adc_code,
	output logic signed [tac_pkg::TEMP_W-1:0] temperature,
	output logic [1:0]                   range_status
);
	import tac_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo_q;
	logic [RES_W-1:0]  rem_q;
	logic [RES_W-1:0]  div_q;
	logic [RES_W-1:0]  r_q;
	logic [SEG_W-1:0]  seg_q;
	logic [1:0]        status_q;
	logic [TEMP_W-1:0] temp_q;
	logic [1:0]        range_q;

	logic [RES_W+1:0]  trial;
	logic [PROD_W-1:0] r_now;
	logic [SEG_W-1:0]  seg_nx;
	logic [RES_W-1:0]  hi, lo, span, diff;
	logic [QUO_W-1:0]  dd;
	logic [FRAC_W-1:0] frac;
	logic [TEMP_W-1:0] temp_interp;

	assign prod   = {{(PROD_W-CODE_W){1'b0}}, code_q} * DIVIDER_R10;
	assign trial  = {1'b0, rem_q, quo_q[QUO_W-1]} - {2'b0, div_q};
	assign r_now  = (code_q == FULL_SCALE) ? {{(PROD_W-RES_W){1'b0}}, res_tab(SEG_W'(0))}
	                                       : quo_q[PROD_W-1:0];
	assign seg_nx = seg_q + SEG_W'(1);
	assign hi     = res_tab(seg_q);
	assign lo     = res_tab(seg_nx);
	assign span   = (hi > lo) ? (hi - lo) : RES_W'(1);
	assign diff   = (hi >= r_q) ? (hi - r_q) : '0;
	// Times 1280 as two shifted copies.
	assign dd     = ({{(QUO_W-RES_W){1'b0}}, diff} << 10) + ({{(QUO_W-RES_W){1'b0}}, diff} << 8);
	assign frac   = (quo_q[FRAC_W-1:0] > STEP_SCALED) ? STEP_SCALED : quo_q[FRAC_W-1:0];
	assign temp_interp = TEMP_W'(seg_q) * STEP_TEMP + TEMP_W'(frac) + COLD_TEMP;

	assign stat.cold     = r_now >= {{(PROD_W-RES_W){1'b0}}, res_tab(SEG_W'(0))};
	assign stat.hot      = r_now <= {{(PROD_W-RES_W){1'b0}}, res_tab(SEG_W'(TABLE_ENTRIES-1))};
	assign stat.hit      = (r_q <= hi) && (r_q >= lo);
	assign stat.seg_last = seg_q == SEG_W'(TABLE_ENTRIES - 2);

	always_ff @(posedge clk) begin
		if (cmd.load_code)
			code_q <= adc_code;
		if (cmd.mul_load) begin
			quo_q <= {prod, {(QUO_W-PROD_W){1'b0}}};
			rem_q <= '0;
			div_q <= RES_W'(FULL_SCALE - code_q);
		end else if (cmd.prep) begin
			quo_q <= {dd[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
			rem_q <= dd[QUO_W-1:FRAC_W];
			div_q <= span;
		end else if (cmd.div_step) begin
			if (!trial[RES_W+1]) begin
				rem_q <= trial[RES_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[RES_W-2:0], quo_q[QUO_W-1]};
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.check) begin
			r_q <= r_now[RES_W-1:0];
			if (stat.cold)
				status_q <= ST_COLD;
			else if (stat.hot)
				status_q <= ST_HOT;
			else
				status_q <= ST_INTERP;
		end
		if (cmd.seg_clr)
			seg_q <= '0;
		else if (cmd.seg_inc)
			seg_q <= seg_nx;
		if (cmd.out_load) begin
			range_q <= status_q;
			case (status_q)
				ST_COLD: temp_q <= COLD_TEMP;
				ST_HOT:  temp_q <= HOT_TEMP;
				default: temp_q <= temp_interp;
			endcase
		end
	end

	assign temperature  = signed'(temp_q);
	assign range_status = range_q;

	// The partial remainder always stays below a non-zero divisor.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && div_q != '0 |-> rem_q < div_q)
		else $error("divider remainder out of range");

	// The search only runs on a resistance strictly inside the table.
	a_search_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_inc |-> r_q < res_tab(SEG_W'(0)) && status_q == ST_INTERP)
		else $error("search on a clamped resistance");

	// A clamped result carries its fixed temperature.
	a_cold_value: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) && range_q == ST_COLD |-> temp_q == COLD_TEMP)
		else $error("cold clamp temperature wrong");

endmodule

// ----- rtl/tac_controller.sv -----
// Controller: sequences multiply, divide, clamp check, search, interpolation and output.
`timescale 1ns / 1ps
module tac_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output tac_pkg::tac_cmd_t  cmd,
	input  tac_pkg::tac_stat_t stat
);
	import tac_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIV, S_CHECK, S_SEARCH, S_PREP, S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load_code = (state_q == S_IDLE) && in_valid;
		cmd.mul_load  = state_q == S_MUL;
		cmd.div_step  = state_q == S_DIV;
		cmd.check     = state_q == S_CHECK;
		cmd.seg_clr   = (state_q == S_CHECK) || ((state_q == S_SEARCH) && !stat.hit && stat.seg_last);
		cmd.seg_inc   = (state_q == S_SEARCH) && !stat.hit && !stat.seg_last;
		cmd.prep      = state_q == S_PREP;
		cmd.out_load  = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= CNT_W'(DIV1_ITERS);
					phase_q <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1))
						state_q <= phase_q ? S_FIN : S_CHECK;
				end
				S_CHECK: begin
					state_q <= (stat.cold || stat.hot) ? S_FIN : S_SEARCH;
				end
				S_SEARCH: begin
					// With no bracketing segment the first one is used.
					if (stat.hit || stat.seg_last)
						state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q   <= CNT_W'(DIV2_ITERS);
					phase_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !cmd.out_load)
		else $error("output register overwritten");

	// A loaded result is offered in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not offered");

	// The divider never runs with an exhausted count.
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q != '0)
		else $error("divider count exhausted");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.load_code)
		else $error("input taken while busy");

endmodule

// ----- rtl/thermistor_adc_to_celsius.sv -----
// Top level: thermistor ADC code to temperature with table interpolation.
// Interpolated results take a 29-step divide for resistance, up to 24 search steps over
// the table and an 11-step divide for the offset within the segment; clamped results skip
// the search and the second divide.
// One item is processed at a time; the next is taken once its result is registered.
// Reset (arst_n, asynchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
module thermistor_adc_to_celsius (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tac_pkg::CODE_W-1:0]         adc_code,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [tac_pkg::TEMP_W-1:0]  temperature,
	output logic [1:0]                         range_status
);
	import tac_pkg::*;

	tac_cmd_t  cmd;
	tac_stat_t stat;

	tac_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	tac_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.adc_code     (adc_code),
		.temperature  (temperature),
		.range_status (range_status)
	);

endmodule

// ----- sim/tac_checker.sv -----
// Checker for the thermistor converter: watches both channels, predicts each temperature and compares.
`timescale 1ns / 1ps
module tac_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [tac_pkg::CODE_W-1:0]         adc_code,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [tac_pkg::TEMP_W-1:0]  temperature,
	input  logic [1:0]                         range_status,
	output int                                 accepted,
	output int                                 retired,
	output int                                 mismatches,
	output int                                 n_interp,
	output int                                 n_cold,
	output int                                 n_hot
);
	import tac_pkg::*;

	localparam longint unsigned R_SCALE   = 100000;
	localparam longint unsigned CODE_TOP  = 4095;
	localparam longint unsigned STEP_FRAC = 1280;
	localparam int              BASE_C    = -20;
	localparam int              STEP_C    = 5;
	localparam int              MAX_PRINT = 50;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [1:0]               status;
	} celsius_t;

	celsius_t pending_q[$];
	int acc_cnt    = 0;
	int ret_cnt    = 0;
	int fail_cnt   = 0;
	int interp_cnt = 0;
	int cold_cnt   = 0;
	int hot_cnt    = 0;

	assign accepted   = acc_cnt;
	assign retired    = ret_cnt;
	assign mismatches = fail_cnt;
	assign n_interp   = interp_cnt;
	assign n_cold     = cold_cnt;
	assign n_hot      = hot_cnt;

	// Points past the standard set of resistances read back as zero.
	function automatic longint unsigned table_point(input int idx);
		if (idx < STD_POINTS)
			return longint'(RES_TAB[idx]);
		return 0;
	endfunction

	function automatic celsius_t convert_code(input logic [CODE_W-1:0] code);
		celsius_t         res;
		longint unsigned  r10;
		longint unsigned  hi;
		longint unsigned  lo;
		longint unsigned  span;
		longint unsigned  offset;
		int               seg;
		bit               found;
		longint unsigned  c;
		c = longint'(code);
		if (c == CODE_TOP)
			r10 = table_point(0);
		else
			r10 = (R_SCALE * c) / (CODE_TOP - c);
		if (r10 >= table_point(0)) begin
			res.temp   = TEMP_W'(BASE_C * 256);
			res.status = ST_COLD;
		end else if (r10 <= table_point(TABLE_ENTRIES - 1)) begin
			res.temp   = TEMP_W'((BASE_C + STEP_C * (TABLE_ENTRIES - 1)) * 256);
			res.status = ST_HOT;
		end else begin
			seg   = 0;
			found = 1'b0;
			for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
				if (!found && r10 <= table_point(i) && r10 >= table_point(i + 1)) begin
					seg   = i;
					found = 1'b1;
				end
			end
			hi     = table_point(seg);
			lo     = table_point(seg + 1);
			span   = (hi > lo) ? (hi - lo) : 1;
			offset = (hi >= r10) ? ((hi - r10) * STEP_FRAC) / span : 0;
			if (offset > STEP_FRAC)
				offset = STEP_FRAC;
			res.temp   = TEMP_W'((BASE_C + STEP_C * seg) * 256 + int'(offset));
			res.status = ST_INTERP;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_cnt < MAX_PRINT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		fail_cnt++;
	endtask

	always @(posedge clk) begin
		celsius_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = convert_code(adc_code);
				pending_q.push_back(want);
				acc_cnt <= acc_cnt + 1;
				case (want.status)
					ST_COLD: cold_cnt <= cold_cnt + 1;
					ST_HOT:  hot_cnt <= hot_cnt + 1;
					default: interp_cnt <= interp_cnt + 1;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					report_mismatch($sformatf("result %0d status %0d with nothing expected",
						temperature, range_status));
				end else begin
					want = pending_q.pop_front();
					if (temperature !== want.temp)
						report_mismatch($sformatf("transfer %0d temperature %0d, expected %0d",
							ret_cnt, temperature, want.temp));
					if (range_status !== want.status)
						report_mismatch($sformatf("transfer %0d status %0d, expected %0d",
							ret_cnt, range_status, want.status));
					ret_cnt <= ret_cnt + 1;
				end
			end
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the thermistor converter testbench: clock, reset, code stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
	import tac_pkg::*;

	localparam int RANDOM_CODES = 950;
	localparam int DRAIN_CYCLES = 80;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic [CODE_W-1:0]         adc_code  = '0;
	logic                      out_stall = 1'b0;
	logic                      in_stall;
	logic                      out_valid;
	logic signed [TEMP_W-1:0]  temperature;
	logic [1:0]                range_status;

	int accepted;
	int retired;
	int mismatches;
	int n_interp;
	int n_cold;
	int n_hot;

	int stall_mode = 0;
	int stall_left = 0;

	thermistor_adc_to_celsius u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.adc_code     (adc_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temperature  (temperature),
		.range_status (range_status)
	);

	tac_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.adc_code     (adc_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temperature  (temperature),
		.range_status (range_status),
		.accepted     (accepted),
		.retired      (retired),
		.mismatches   (mismatches),
		.n_interp     (n_interp),
		.n_cold       (n_cold),
		.n_hot        (n_hot)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver runs through phases: free, held off, and two densities of random stalling.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(1, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= 1'b1;
			2:       out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		logic [CODE_W-1:0] code_q[$];
		int burst_left;
		int gap;
		int pick;
		// Extremes, mid-scale and alternating bit patterns, and codes either side of the cold and hot clamp points.
		code_q = '{12'd0, 12'd1, 12'd4095, 12'd4094, 12'h800, 12'h7FF, 12'h555, 12'hAAA,
			12'd2047, 12'd2048, 12'd3765, 12'd3766, 12'd3767, 12'd3768, 12'd212, 12'd213,
			12'd214, 12'd215, 12'd1000, 12'd3000, 12'd3500, 12'd600};
		for (int k = 0; k < RANDOM_CODES; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				code_q.push_back(CODE_W'($urandom_range(0, 4095)));
			else if (pick < 85)
				code_q.push_back(CODE_W'($urandom_range(3740, 4095)));
			else
				code_q.push_back(CODE_W'($urandom_range(0, 240)));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 12);
		foreach (code_q[k]) begin
			in_valid <= 1'b1;
			adc_code <= code_q[k];
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			burst_left--;
			if (burst_left == 0) begin
				gap = $urandom_range(1, 80);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
			end
		end
		in_valid <= 1'b0;
		// Let the checker count the last input transfer before comparing totals.
		@(posedge clk);

		while (retired != accepted)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d codes: %0d interpolated, %0d clamped cold, %0d clamped hot.",
			accepted, n_interp, n_cold, n_hot);
		$display("%0d results checked under random sender gaps and receiver stalls, %0d mismatches.",
			retired, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d transfers in and %0d out.", accepted, retired);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
